@@ sv/segment_intersection_macros.svh @@
// Assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
`ifndef SYNTH
`define SI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment_intersection check failed");
`define SI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment_intersection check failed");
`else
`define SI_ASSERT_IMP(label, ante, cons)
`define SI_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ sv/si_pkg.sv @@
// Shared constants and types of the segment intersection block
package si_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int OUT_BITS       = 24;

	typedef struct packed {
		logic valid;
		logic hit;
		logic neg_x;
		logic neg_y;
	} si_ctrl_t;
endpackage

@@ sv/si_cell.sv @@
// One restoring-division cell: one quotient bit for the x and y lanes
module si_cell import si_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int DW = 49,
	parameter int MW = 33,
	parameter int QW = 24,
	parameter int K = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  si_ctrl_t                     up_ctrl,
	input  logic signed [COORD_BITS-1:0] up_x1,
	input  logic signed [COORD_BITS-1:0] up_y1,
	input  logic [MW-1:0]                up_div,
	input  logic [DW-1:0]                up_rem_x,
	input  logic [DW-1:0]                up_rem_y,
	input  logic [QW-1:0]                up_q_x,
	input  logic [QW-1:0]                up_q_y,
	output si_ctrl_t                     dn_ctrl,
	output logic signed [COORD_BITS-1:0] dn_x1,
	output logic signed [COORD_BITS-1:0] dn_y1,
	output logic [MW-1:0]                dn_div,
	output logic [DW-1:0]                dn_rem_x,
	output logic [DW-1:0]                dn_rem_y,
	output logic [QW-1:0]                dn_q_x,
	output logic [QW-1:0]                dn_q_y
);
	logic [DW:0] sub_d;
	logic [DW:0] trial_x;
	logic [DW:0] trial_y;
	logic        take_x;
	logic        take_y;

	always_comb begin
		sub_d   = (DW + 1)'(up_div) << K;
		trial_x = {1'b0, up_rem_x} - sub_d;
		trial_y = {1'b0, up_rem_y} - sub_d;
		take_x  = !trial_x[DW];
		take_y  = !trial_y[DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_ctrl <= '0;
		end else begin
			dn_ctrl <= up_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		dn_x1    <= up_x1;
		dn_y1    <= up_y1;
		dn_div   <= up_div;
		dn_rem_x <= take_x ? trial_x[DW-1:0] : up_rem_x;
		dn_rem_y <= take_y ? trial_y[DW-1:0] : up_rem_y;
		dn_q_x   <= {up_q_x[QW-2:0], take_x};
		dn_q_y   <= {up_q_y[QW-2:0], take_y};
	end
endmodule

@@ sv/segment_intersection.sv @@
// Top level of the segment intersection block
// Usage:
//   Raise start with the eight endpoint coordinates of segments A and B on
//   ax0..by1. busy is held low: a transfer is taken at every clock edge at
//   which start is high, so one pair of segments enters per cycle.
//   Each transfer yields one result: done is high for exactly one cycle with
//   hit, cross_x and cross_y valid in that cycle. Results leave in order.
//   From the accepting edge an item passes through registers for the
//   differences, products, cross terms and scaling multiplies, then one
//   cell per quotient bit in the division chain, and the output register.
//   Throughput is one item per cycle; the division chain holds up to
//   COORD_BITS + FRAC_BITS items in flight, one in each cell.
//   The receiver cannot stall: results are shown once and must be taken.
//   Reset clears all valid flags; items in flight are dropped.
`include "segment_intersection_macros.svh"
module segment_intersection import si_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] ax0,
	input  logic signed [COORD_BITS-1:0] ay0,
	input  logic signed [COORD_BITS-1:0] ax1,
	input  logic signed [COORD_BITS-1:0] ay1,
	input  logic signed [COORD_BITS-1:0] bx0,
	input  logic signed [COORD_BITS-1:0] by0,
	input  logic signed [COORD_BITS-1:0] bx1,
	input  logic signed [COORD_BITS-1:0] by1,
	output logic                         done,
	output logic                         hit,
	output logic signed [OUT_BITS-1:0]   cross_x,
	output logic signed [OUT_BITS-1:0]   cross_y
);
	localparam int DF   = COORD_BITS + 1;
	localparam int NW   = 2 * COORD_BITS + 2;
	localparam int MW   = 2 * COORD_BITS + 1;
	localparam int DW   = MW + COORD_BITS + FRAC_BITS;
	localparam int QW   = COORD_BITS + FRAC_BITS;
	localparam int SUMW = COORD_BITS + FRAC_BITS + 2;
	localparam int EW   = ((SUMW > OUT_BITS) ? SUMW : OUT_BITS) + 1;
	localparam int PW   = MW + COORD_BITS;

	assign busy = 1'b0;

	// differences
	logic                         v_s1;
	logic signed [DF-1:0]         dxa_s1, dya_s1, dxb_s1, dyb_s1, ox_s1, oy_s1;
	logic signed [COORD_BITS-1:0] x1_s1, y1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dxa_s1 <= DF'(ax1) - DF'(ax0);
		dya_s1 <= DF'(ay1) - DF'(ay0);
		dxb_s1 <= DF'(bx1) - DF'(bx0);
		dyb_s1 <= DF'(by1) - DF'(by0);
		ox_s1  <= DF'(ax0) - DF'(bx0);
		oy_s1  <= DF'(ay0) - DF'(by0);
		x1_s1  <= ax0;
		y1_s1  <= ay0;
	end

	// products
	logic                         v_s2;
	logic signed [NW-1:0]         p_den0_s2, p_den1_s2, p_na0_s2, p_na1_s2, p_nb0_s2, p_nb1_s2;
	logic signed [DF-1:0]         dxa_s2, dya_s2;
	logic signed [COORD_BITS-1:0] x1_s2, y1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_den0_s2 <= NW'(dyb_s1) * NW'(dxa_s1);
		p_den1_s2 <= NW'(dxb_s1) * NW'(dya_s1);
		p_na0_s2  <= NW'(dxb_s1) * NW'(oy_s1);
		p_na1_s2  <= NW'(dyb_s1) * NW'(ox_s1);
		p_nb0_s2  <= NW'(dxa_s1) * NW'(oy_s1);
		p_nb1_s2  <= NW'(dya_s1) * NW'(ox_s1);
		dxa_s2    <= dxa_s1;
		dya_s2    <= dya_s1;
		x1_s2     <= x1_s1;
		y1_s2     <= y1_s1;
	end

	// cross terms and range test
	logic signed [NW-1:0] den_c, numa_c, numb_c;
	logic                 unit_a, unit_b, hit_c;

	always_comb begin
		den_c  = p_den0_s2 - p_den1_s2;
		numa_c = p_na0_s2 - p_na1_s2;
		numb_c = p_nb0_s2 - p_nb1_s2;
		if (den_c > 0) begin
			unit_a = (numa_c >= 0) && (numa_c <= den_c);
			unit_b = (numb_c >= 0) && (numb_c <= den_c);
		end else begin
			unit_a = (numa_c <= 0) && (numa_c >= den_c);
			unit_b = (numb_c <= 0) && (numb_c >= den_c);
		end
		hit_c = (den_c != 0) && unit_a && unit_b;
	end

	logic                         v_s3, hit_s3;
	logic signed [NW-1:0]         den_s3, numa_s3;
	logic signed [DF-1:0]         dxa_s3, dya_s3;
	logic signed [COORD_BITS-1:0] x1_s3, y1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		hit_s3  <= hit_c;
		den_s3  <= den_c;
		numa_s3 <= numa_c;
		dxa_s3  <= dxa_s2;
		dya_s3  <= dya_s2;
		x1_s3   <= x1_s2;
		y1_s3   <= y1_s2;
	end

	// magnitudes and scaled dividends
	logic [NW-1:0] abs_den, abs_na;
	logic [DF-1:0] abs_dxa, abs_dya;
	logic [PW-1:0] mul_x, mul_y;

	always_comb begin
		abs_den = den_s3[NW-1] ? NW'(-den_s3) : NW'(den_s3);
		abs_na  = numa_s3[NW-1] ? NW'(-numa_s3) : NW'(numa_s3);
		abs_dxa = dxa_s3[DF-1] ? DF'(-dxa_s3) : DF'(dxa_s3);
		abs_dya = dya_s3[DF-1] ? DF'(-dya_s3) : DF'(dya_s3);
		mul_x   = PW'(abs_na[MW-1:0]) * PW'(abs_dxa[COORD_BITS-1:0]);
		mul_y   = PW'(abs_na[MW-1:0]) * PW'(abs_dya[COORD_BITS-1:0]);
	end

	si_ctrl_t                     ctrl_c[QW+1];
	logic signed [COORD_BITS-1:0] x1_c[QW+1];
	logic signed [COORD_BITS-1:0] y1_c[QW+1];
	logic [MW-1:0]                div_c[QW+1];
	logic [DW-1:0]                rem_x_c[QW+1];
	logic [DW-1:0]                rem_y_c[QW+1];
	logic [QW-1:0]                q_x_c[QW+1];
	logic [QW-1:0]                q_y_c[QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_c[0] <= '0;
		end else begin
			ctrl_c[0] <= '{valid: v_s3, hit: hit_s3,
				neg_x: numa_s3[NW-1] ^ dxa_s3[DF-1] ^ den_s3[NW-1],
				neg_y: numa_s3[NW-1] ^ dya_s3[DF-1] ^ den_s3[NW-1]};
		end
	end

	always_ff @(posedge clk) begin
		x1_c[0]    <= x1_s3;
		y1_c[0]    <= y1_s3;
		div_c[0]   <= abs_den[MW-1:0];
		rem_x_c[0] <= DW'(mul_x) << FRAC_BITS;
		rem_y_c[0] <= DW'(mul_y) << FRAC_BITS;
		q_x_c[0]   <= '0;
		q_y_c[0]   <= '0;
	end

	for (genvar i = 0; i < QW; i++) begin : g_cell
		si_cell #(
			.COORD_BITS(COORD_BITS), .DW(DW), .MW(MW), .QW(QW), .K(QW - 1 - i)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_ctrl(ctrl_c[i]), .up_x1(x1_c[i]), .up_y1(y1_c[i]),
			.up_div(div_c[i]), .up_rem_x(rem_x_c[i]), .up_rem_y(rem_y_c[i]),
			.up_q_x(q_x_c[i]), .up_q_y(q_y_c[i]),
			.dn_ctrl(ctrl_c[i+1]), .dn_x1(x1_c[i+1]), .dn_y1(y1_c[i+1]),
			.dn_div(div_c[i+1]), .dn_rem_x(rem_x_c[i+1]), .dn_rem_y(rem_y_c[i+1]),
			.dn_q_x(q_x_c[i+1]), .dn_q_y(q_y_c[i+1])
		);
	end

	// sign, offset and saturation
	si_ctrl_t                   tail;
	logic signed [SUMW-1:0]     qs_x, qs_y, sum_x, sum_y;
	logic signed [EW-1:0]       ext_x, ext_y;
	logic signed [EW-1:0]       lim_hi, lim_lo;
	logic signed [OUT_BITS-1:0] sat_x, sat_y;

	always_comb begin
		tail   = ctrl_c[QW];
		qs_x   = tail.neg_x ? -$signed(SUMW'(q_x_c[QW])) : $signed(SUMW'(q_x_c[QW]));
		qs_y   = tail.neg_y ? -$signed(SUMW'(q_y_c[QW])) : $signed(SUMW'(q_y_c[QW]));
		sum_x  = (SUMW'(x1_c[QW]) <<< FRAC_BITS) + qs_x;
		sum_y  = (SUMW'(y1_c[QW]) <<< FRAC_BITS) + qs_y;
		ext_x  = EW'(sum_x);
		ext_y  = EW'(sum_y);
		lim_hi = (EW'(1) <<< (OUT_BITS - 1)) - EW'(1);
		lim_lo = -(EW'(1) <<< (OUT_BITS - 1));
		if (ext_x > lim_hi) begin
			sat_x = lim_hi[OUT_BITS-1:0];
		end else if (ext_x < lim_lo) begin
			sat_x = lim_lo[OUT_BITS-1:0];
		end else begin
			sat_x = ext_x[OUT_BITS-1:0];
		end
		if (ext_y > lim_hi) begin
			sat_y = lim_hi[OUT_BITS-1:0];
		end else if (ext_y < lim_lo) begin
			sat_y = lim_lo[OUT_BITS-1:0];
		end else begin
			sat_y = ext_y[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit     <= tail.hit;
		cross_x <= tail.hit ? sat_x : '0;
		cross_y <= tail.hit ? sat_y : '0;
	end

	`SI_ASSERT_IMP(a_miss_zero, done && !hit, cross_x == 0 && cross_y == 0)
	`SI_ASSERT_NXT(a_tail_done, tail.valid, done)
	`SI_ASSERT_NXT(a_start_s1, start && !busy, v_s1)
	`SI_ASSERT_IMP(a_hit_den, v_s3 && hit_s3, den_s3 != 0)
endmodule

@@ dv/tb_segment_intersection.sv @@
// Self-checking testbench of the segment intersection block
`timescale 1ns / 100ps
module tb_segment_intersection;
	import si_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = CB + FB + 5;
	localparam int N_RANDOM = 450;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0] out_t;

	typedef struct {
		coord_t c [8];
	} seg_pair_t;

	typedef struct {
		logic hit;
		out_t x;
		out_t y;
	} crossing_t;

	typedef struct {
		coord_t c [8];
		bit     known;
		crossing_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t ax0 = '0, ay0 = '0, ax1 = '0, ay1 = '0;
	coord_t bx0 = '0, by0 = '0, bx1 = '0, by1 = '0;
	logic done, hit;
	out_t cross_x, cross_y;

	crossing_t pending_crossings [$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 1'b0;
	bit idle_off = 1'b0;

	segment_intersection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ax0(ax0), .ay0(ay0), .ax1(ax1), .ay1(ay1),
		.bx0(bx0), .by0(by0), .bx1(bx1), .by1(by1),
		.done(done), .hit(hit), .cross_x(cross_x), .cross_y(cross_y)
	);

	always #2 clk = ~clk;

	function automatic logic signed [127:0] trunc_div(logic signed [127:0] n,
			logic signed [127:0] d);
		logic [127:0] an, ad, q;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		q = an / ad;
		return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
	endfunction

	function automatic out_t clamp_out(logic signed [127:0] v);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (OUT_BITS - 1)) - 128'sd1;
		lo = -(128'sd1 <<< (OUT_BITS - 1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[OUT_BITS-1:0];
	endfunction

	function automatic bit param_in_unit(logic signed [127:0] n, logic signed [127:0] d);
		if (d > 0) return n >= 0 && n <= d;
		return n <= 0 && n >= d;
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t p);
		logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
		logic signed [127:0] dxa, dya, dxb, dyb, ox, oy, den, na, nb;
		crossing_t r;
		x1 = 128'(p.c[0]); y1 = 128'(p.c[1]); x2 = 128'(p.c[2]); y2 = 128'(p.c[3]);
		x3 = 128'(p.c[4]); y3 = 128'(p.c[5]); x4 = 128'(p.c[6]); y4 = 128'(p.c[7]);
		dxa = x2 - x1; dya = y2 - y1; dxb = x4 - x3; dyb = y4 - y3;
		ox = x1 - x3; oy = y1 - y3;
		den = dyb * dxa - dxb * dya;
		na = dxb * oy - dyb * ox;
		nb = dxa * oy - dya * ox;
		r.hit = 1'b0; r.x = '0; r.y = '0;
		if (den != 0 && param_in_unit(na, den) && param_in_unit(nb, den)) begin
			r.hit = 1'b1;
			r.x = clamp_out((x1 <<< FB) + trunc_div((na * dxa) <<< FB, den));
			r.y = clamp_out((y1 <<< FB) + trunc_div((na * dya) <<< FB, den));
		end
		return r;
	endfunction

	task automatic idle_burst();
		repeat ($urandom_range(1, 11)) @(negedge clk);
	endtask

	task automatic send_pair(seg_pair_t p, bit known, crossing_t res);
		{ax0, ay0, ax1, ay1} = {p.c[0], p.c[1], p.c[2], p.c[3]};
		{bx0, by0, bx1, by1} = {p.c[4], p.c[5], p.c[6], p.c[7]};
		start = 1'b1;
		do @(posedge clk); while (busy);
		pending_crossings.push_back(known ? res : predict_crossing(p));
		@(negedge clk);
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			idle_burst();
		end
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 64)) - 32);
			default: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	function automatic stim_row_t row(int a, int b, int c, int d, int e, int f, int g,
			int h, bit known, logic ht, int rx, int ry);
		stim_row_t s;
		s.c = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
			coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
		s.known = known;
		s.res.hit = ht; s.res.x = out_t'(rx); s.res.y = out_t'(ry);
		return s;
	endfunction

	initial begin
		stim_row_t directed [$];
		seg_pair_t p;
		crossing_t none;
		int mode;
		none = '{hit: 1'b0, x: '0, y: '0};
		directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		directed.push_back(row(0, 0, 10, 10, 0, 10, 10, 0, 1, 1, 5 * 256, 5 * 256));
		directed.push_back(row(0, 0, 10, 0, 0, 1, 10, 1, 1, 0, 0, 0));
		directed.push_back(row(0, 0, 10, 0, 2, 0, 20, 0, 1, 0, 0, 0));
		directed.push_back(row(0, 0, 10, 0, 10, 0, 10, 5, 1, 1, 10 * 256, 0));
		directed.push_back(row(0, 0, 10, 0, 0, 0, 0, 5, 1, 1, 0, 0));
		directed.push_back(row(0, 0, 10, 0, 11, -5, 11, 5, 1, 0, 0, 0));
		directed.push_back(row(-32768, -32768, 32767, 32767, -32768, 32767, 32767,
			-32768, 0, 0, 0, 0));
		directed.push_back(row(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1, 1, 0, 0));
		directed.push_back(row(32767, 32767, 32767, -32768, -32768, 32767, 32767, 32767,
			1, 1, 32767 * 256, 32767 * 256));
		directed.push_back(row(-32768, -32768, -32768, 32767, -32768, -32768, 32767,
			-32768, 1, 1, -32768 * 256, -32768 * 256));
		directed.push_back(row(0, 0, 3, 1, 0, 1, 3, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, -3, 7, 0, 5, -3, -1, 0, 0, 0, 0));
		directed.push_back(row(-1, -1, -1, -1, -1, -1, -1, -1, 1, 0, 0, 0));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i]) begin
			p.c = directed[i].c;
			send_pair(p, directed[i].known, directed[i].res);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				start = 1'b0;
				wait (pending_crossings.size() == 0);
				@(negedge clk);
			end
			if (n == N_RANDOM - 60) idle_off = 1'b1;
			mode = $urandom_range(0, 2);
			foreach (p.c[k]) p.c[k] = rand_coord(mode);
			if ($urandom_range(0, 9) == 0) begin
				p.c[6] = coord_t'(p.c[4] + 2 * (p.c[2] - p.c[0]));
				p.c[7] = coord_t'(p.c[5] + 2 * (p.c[3] - p.c[1]));
			end
			send_pair(p, 1'b0, none);
		end
		start = 1'b0;
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		crossing_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_crossings.size() == 0) begin
				$display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, hit,
					cross_x, cross_y);
				errors <= errors + 1;
			end else begin
				e = pending_crossings.pop_front();
				if (e.hit !== hit || e.x !== cross_x || e.y !== cross_y) begin
					$display("%0t: expected hit=%0b x=%0d y=%0d, actual hit=%0b x=%0d y=%0d",
						$time, e.hit, e.x, e.y, hit, cross_x, cross_y);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		wait (stim_done && pending_crossings.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && pending_crossings.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
